// ===== design/rct_pkg.sv =====
package rct_pkg;

    // limits on the element count and on one bulk length
    localparam int MAX_ELEMENTS = 256;
    localparam int MAX_BULK_LEN = 65535;

    // derived widths
    localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
    localparam int LEN_W = $clog2(MAX_BULK_LEN + 1);
    localparam int ACC_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;

    // one input byte causes at most this many results
    localparam int MAX_RES = 3;
    localparam int RES_IDX_W = $clog2(MAX_RES);
    localparam int RES_CNT_W = $clog2(MAX_RES + 1);

    // characters
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    typedef enum logic [3:0] {
        PH_FIRST,
        PH_INLINE,
        PH_COUNT,
        PH_COUNT_LF,
        PH_DOLLAR,
        PH_LEN,
        PH_LEN_LF,
        PH_PAYLOAD,
        PH_SKIP,
        PH_DONE,
        PH_STOP
    } t_phase;

    typedef enum logic [1:0] {
        KIND_BYTE,
        KIND_END,
        KIND_FINISH
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK,
        ST_STOP,
        ST_TRUNC
    } t_status;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  token_byte;
        logic [7:0]  token_index;
        t_status     status;
        logic [8:0]  token_count;
        logic        run_last;
    } t_result;

    typedef struct packed {
        logic [RES_CNT_W-1:0]      cnt;
        t_result [MAX_RES-1:0]     slot;
    } t_bundle;

    // build one result; token_count is only carried by a finish
    function automatic t_result mk_result(
        input t_kind            kind,
        input logic [7:0]       data,
        input logic [CNT_W-1:0] idx,
        input t_status          status
    );
        t_result r;
        r.kind        = kind;
        r.token_byte  = data;
        r.token_index = 8'(idx);
        r.status      = status;
        r.token_count = (kind == KIND_FINISH) ? 9'(idx) : 9'd0;
        r.run_last    = 1'b0;
        return r;
    endfunction

    // decimal accumulate with saturation
    function automatic logic [ACC_W-1:0] num_next(
        input logic [ACC_W-1:0] acc,
        input logic [7:0]       data,
        input logic [ACC_W-1:0] limit
    );
        logic [ACC_W+3:0] v;
        v = {acc, 3'b000} + {acc, 1'b0} + (ACC_W+4)'(data[3:0]);
        return (v > (ACC_W+4)'(limit)) ? limit : v[ACC_W-1:0];
    endfunction

endpackage

// ===== design/rct_if.sv =====
interface rct_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       last_byte;

    modport source (output valid, output in_byte, output last_byte, input ready);
    modport sink   (input valid, input in_byte, input last_byte, output ready);
endinterface

interface rct_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] token_byte;
    logic [7:0] token_index;
    logic [1:0] status;
    logic [8:0] token_count;
    logic       run_last;

    modport source (
        output valid, output kind, output token_byte, output token_index,
        output status, output token_count, output run_last, input ready
    );
    modport sink (
        input valid, input kind, input token_byte, input token_index,
        input status, input token_count, input run_last, output ready
    );
endinterface

// ===== design/rct_parser.sv =====
module rct_parser (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_take,
    input  logic [7:0]          i_byte,
    input  logic                i_last,
    output rct_pkg::t_bundle    o_bundle
);

    rct_pkg::t_phase                r_phase, n_phase;
    logic                           r_in_tok, n_in_tok;
    logic [rct_pkg::ACC_W-1:0]      r_acc, n_acc;
    logic [rct_pkg::CNT_W-1:0]      r_elem, n_elem;
    logic [rct_pkg::LEN_W-1:0]      r_bytes, n_bytes;
    logic [rct_pkg::CNT_W-1:0]      r_idx, n_idx;
    logic [1:0]                     r_skip, n_skip;

    logic                           num_go, num_done, num_cont;
    logic [rct_pkg::ACC_W-1:0]      num_lim;
    rct_pkg::t_phase                num_base, num_lfp;
    logic                           do_inline, do_byte, do_end, ws, is_digit;
    logic [rct_pkg::RES_CNT_W-1:0]  cnt;
    rct_pkg::t_status               fin_status;
    rct_pkg::t_bundle               bnd;

    // one byte of parsing: next state and up to three results
    always_comb begin
        n_phase   = r_phase;
        n_in_tok  = r_in_tok;
        n_acc     = r_acc;
        n_elem    = r_elem;
        n_bytes   = r_bytes;
        n_idx     = r_idx;
        n_skip    = r_skip;
        num_go    = 1'b0;
        num_done  = 1'b0;
        num_cont  = 1'b1;
        num_lim   = rct_pkg::ACC_W'(rct_pkg::MAX_ELEMENTS);
        num_base  = rct_pkg::PH_COUNT;
        num_lfp   = rct_pkg::PH_COUNT_LF;
        do_inline = 1'b0;
        do_byte   = 1'b0;
        do_end    = 1'b0;
        cnt       = '0;
        bnd       = '0;
        fin_status = rct_pkg::ST_OK;
        ws = (i_byte == rct_pkg::CH_SPACE) ||
             ((i_byte >= rct_pkg::CH_TAB) && (i_byte <= rct_pkg::CH_CR));
        is_digit = (i_byte >= rct_pkg::CH_ZERO) && (i_byte <= rct_pkg::CH_NINE);

        unique case (r_phase)
            rct_pkg::PH_FIRST: begin
                if (i_byte == rct_pkg::CH_STAR) begin
                    n_acc   = '0;
                    n_phase = rct_pkg::PH_COUNT;
                end else begin
                    n_phase   = rct_pkg::PH_INLINE;
                    do_inline = 1'b1;
                end
            end
            rct_pkg::PH_INLINE: begin
                do_inline = 1'b1;
            end
            rct_pkg::PH_COUNT, rct_pkg::PH_COUNT_LF: begin
                num_go = 1'b1;
            end
            rct_pkg::PH_DOLLAR: begin
                if (i_byte == rct_pkg::CH_DOLLAR) begin
                    n_acc   = '0;
                    n_phase = rct_pkg::PH_LEN;
                end else begin
                    n_phase = rct_pkg::PH_STOP;
                end
            end
            rct_pkg::PH_LEN, rct_pkg::PH_LEN_LF: begin
                num_go   = 1'b1;
                num_lim  = rct_pkg::ACC_W'(rct_pkg::MAX_BULK_LEN);
                num_base = rct_pkg::PH_LEN;
                num_lfp  = rct_pkg::PH_LEN_LF;
            end
            rct_pkg::PH_PAYLOAD: begin
                do_byte = 1'b1;
                if (r_bytes != '0) begin
                    n_bytes = r_bytes - 1'b1;
                end
                if (n_bytes == '0) begin
                    do_end = 1'b1;
                end
            end
            rct_pkg::PH_SKIP: begin
                if (r_skip != 2'd0) begin
                    n_skip = r_skip - 2'd1;
                end
                if (n_skip == 2'd0) begin
                    n_phase = (r_elem != '0) ? rct_pkg::PH_DOLLAR : rct_pkg::PH_DONE;
                end
            end
            rct_pkg::PH_DONE: begin
            end
            default: begin
                n_phase = rct_pkg::PH_STOP;
            end
        endcase

        // decimal number ended by cr lf
        if (num_go) begin
            if (r_phase == num_lfp) begin
                if (i_byte == rct_pkg::CH_LF) begin
                    num_done = 1'b1;
                    num_cont = 1'b0;
                end else if (i_byte == rct_pkg::CH_CR) begin
                    num_cont = 1'b0;
                end else begin
                    n_phase = num_base;
                end
            end
            if (num_cont) begin
                if (i_byte == rct_pkg::CH_CR) begin
                    n_phase = num_lfp;
                end else if (is_digit) begin
                    n_acc = rct_pkg::num_next(r_acc, i_byte, num_lim);
                end
            end
            if (num_done) begin
                if (num_base == rct_pkg::PH_COUNT) begin
                    n_elem  = rct_pkg::CNT_W'(r_acc);
                    n_phase = (r_acc != '0) ? rct_pkg::PH_DOLLAR : rct_pkg::PH_DONE;
                end else begin
                    n_bytes = rct_pkg::LEN_W'(r_acc);
                    if (r_acc == '0) begin
                        do_end = 1'b1;
                    end else begin
                        n_phase = rct_pkg::PH_PAYLOAD;
                    end
                end
            end
        end

        // whitespace split
        if (do_inline) begin
            if (ws) begin
                if (n_in_tok) begin
                    bnd.slot[cnt[rct_pkg::RES_IDX_W-1:0]] = rct_pkg::mk_result(
                        rct_pkg::KIND_END, 8'd0, n_idx, rct_pkg::ST_OK);
                    cnt      = cnt + 1'b1;
                    n_in_tok = 1'b0;
                    n_idx    = n_idx + 1'b1;
                end
            end else if (!n_in_tok &&
                         (n_idx >= rct_pkg::CNT_W'(rct_pkg::MAX_ELEMENTS))) begin
                n_phase = rct_pkg::PH_STOP;
            end else begin
                n_in_tok = 1'b1;
                do_byte  = 1'b1;
            end
        end

        // token byte
        if (do_byte) begin
            bnd.slot[cnt[rct_pkg::RES_IDX_W-1:0]] = rct_pkg::mk_result(
                rct_pkg::KIND_BYTE, i_byte, n_idx, rct_pkg::ST_OK);
            cnt = cnt + 1'b1;
        end

        // end of a bulk token
        if (do_end) begin
            bnd.slot[cnt[rct_pkg::RES_IDX_W-1:0]] = rct_pkg::mk_result(
                rct_pkg::KIND_END, 8'd0, n_idx, rct_pkg::ST_OK);
            cnt   = cnt + 1'b1;
            n_idx = n_idx + 1'b1;
            if (n_elem != '0) begin
                n_elem = n_elem - 1'b1;
            end
            n_skip  = 2'd2;
            n_phase = rct_pkg::PH_SKIP;
        end

        // message close on the last byte
        if (i_last) begin
            if ((n_phase == rct_pkg::PH_INLINE) && n_in_tok) begin
                bnd.slot[cnt[rct_pkg::RES_IDX_W-1:0]] = rct_pkg::mk_result(
                    rct_pkg::KIND_END, 8'd0, n_idx, rct_pkg::ST_OK);
                cnt   = cnt + 1'b1;
                n_idx = n_idx + 1'b1;
            end
            unique case (n_phase)
                rct_pkg::PH_INLINE, rct_pkg::PH_DONE: fin_status = rct_pkg::ST_OK;
                rct_pkg::PH_PAYLOAD: fin_status = rct_pkg::ST_TRUNC;
                rct_pkg::PH_SKIP:
                    fin_status = (n_elem != '0) ? rct_pkg::ST_STOP : rct_pkg::ST_OK;
                default: fin_status = rct_pkg::ST_STOP;
            endcase
            bnd.slot[cnt[rct_pkg::RES_IDX_W-1:0]] = rct_pkg::mk_result(
                rct_pkg::KIND_FINISH, 8'd0, n_idx, fin_status);
            cnt      = cnt + 1'b1;
            n_phase  = rct_pkg::PH_FIRST;
            n_in_tok = 1'b0;
            n_acc    = '0;
            n_elem   = '0;
            n_bytes  = '0;
            n_idx    = '0;
            n_skip   = 2'd0;
        end

        // flag the last result of this byte
        if (cnt != '0) begin
            bnd.slot[rct_pkg::RES_IDX_W'(cnt - 1'b1)].run_last = 1'b1;
        end
        bnd.cnt = cnt;
    end

    assign o_bundle = bnd;

    // parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= rct_pkg::PH_FIRST;
            r_in_tok <= 1'b0;
            r_acc    <= '0;
            r_elem   <= '0;
            r_bytes  <= '0;
            r_idx    <= '0;
            r_skip   <= 2'd0;
        end else if (i_take) begin
            r_phase  <= n_phase;
            r_in_tok <= n_in_tok;
            r_acc    <= n_acc;
            r_elem   <= n_elem;
            r_bytes  <= n_bytes;
            r_idx    <= n_idx;
            r_skip   <= n_skip;
        end
    end

endmodule

// ===== design/rct_outq.sv =====
module rct_outq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  rct_pkg::t_bundle    i_bundle,
    output logic                o_load_ok,
    input  logic                i_ready,
    output logic                o_valid,
    output rct_pkg::t_result    o_result
);

    rct_pkg::t_result [rct_pkg::MAX_RES-1:0]   r_slot;
    logic [rct_pkg::RES_CNT_W-1:0]              r_left;
    logic [rct_pkg::RES_IDX_W-1:0]              r_pos;
    logic                                       take;

    assign o_valid   = (r_left != '0);
    assign take      = o_valid && i_ready;
    assign o_result  = r_slot[r_pos];
    // a new bundle fits once the one held is empty or its last result leaves now
    assign o_load_ok = (r_left == '0) ||
                       ((r_left == rct_pkg::RES_CNT_W'(1)) && i_ready);

    // result payload
    always_ff @(posedge i_clk) begin
        if (i_load && (i_bundle.cnt != '0)) begin
            r_slot <= i_bundle.slot;
        end
    end

    // drain counter and read pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
            r_pos  <= '0;
        end else if (i_load && (i_bundle.cnt != '0)) begin
            r_left <= i_bundle.cnt;
            r_pos  <= '0;
        end else if (take) begin
            r_left <= r_left - 1'b1;
            r_pos  <= r_pos + 1'b1;
        end
    end

endmodule

// ===== design/resp_command_tokenizer_core.sv =====
// Command tokenizer: takes one message byte per request and flags the final
// one with last_byte. A message starting with '*' is parsed as an array of
// bulk strings, anything else is split at whitespace. Each request yields
// zero to three results (token byte, token end, message finished), carried
// out one per cycle, while the sink is ready, from a three-entry result
// register. A new byte is taken every cycle as long as each byte gives at
// most one result and the sink is ready; a byte that gives two or three
// results holds the input while the result register drains. The first
// result of an accepted byte is shown in the cycle after it is taken.
// Element counts saturate at 256 and bulk lengths at 65535.
module resp_command_tokenizer_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rct_in_if.sink      i_in,
    rct_out_if.source   o_out
);

    logic               accept;
    logic               load_ok;
    rct_pkg::t_bundle   bundle;
    rct_pkg::t_result   result;

    assign accept     = i_in.valid && load_ok;
    assign i_in.ready = load_ok;

    // byte parser and state
    rct_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_take   (accept),
        .i_byte   (i_in.in_byte),
        .i_last   (i_in.last_byte),
        .o_bundle (bundle)
    );

    // result register and serializer
    rct_outq u_outq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (accept),
        .i_bundle  (bundle),
        .o_load_ok (load_ok),
        .i_ready   (o_out.ready),
        .o_valid   (o_out.valid),
        .o_result  (result)
    );

    assign o_out.kind        = result.kind;
    assign o_out.token_byte  = result.token_byte;
    assign o_out.token_index = result.token_index;
    assign o_out.status      = result.status;
    assign o_out.token_count = result.token_count;
    assign o_out.run_last    = result.run_last;

endmodule

// ===== design/rct_checker.sv =====
module rct_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_ready,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [1:0]  i_kind,
    input  logic [1:0]  i_status,
    input  logic [8:0]  i_token_count,
    input  logic        i_run_last
);

    // a finish is always the last result of its byte
    a_finish_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_kind == rct_pkg::KIND_FINISH)) |-> i_run_last)
        else $error("finish result without run_last");

    // status and count only on a finish
    a_fields_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_kind != rct_pkg::KIND_FINISH)) |->
            ((i_status == 2'd0) && (i_token_count == 9'd0)))
        else $error("status or count set on a non-finish result");

    // empty output side always takes a request
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with no result pending");

    // no result right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !i_out_valid)
        else $error("result shown after reset");

    // stalled result stays
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_kind)))
        else $error("stalled result dropped");

endmodule

bind resp_command_tokenizer_core rct_checker u_rct_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_kind        (o_out.kind),
    .i_status      (o_out.status),
    .i_token_count (o_out.token_count),
    .i_run_last    (o_out.run_last)
);

// ===== verif/resp_command_tokenizer_core_test.sv =====
module resp_command_tokenizer_core_test;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_BYTES  = 385;
    localparam int CALM_FROM     = 310;
    localparam int HOLD_AFTER    = 60;
    localparam int HOLD_CYCLES   = 400;
    localparam int DRAIN_CYCLES  = 20;

    // tracks parser state and holds the results each request should produce
    class tokenizer_scoreboard;
        rct_pkg::t_phase  phase;
        logic             tok_open;
        logic [16:0]      num_acc;
        logic [8:0]       elems_left;
        logic [16:0]      bytes_left;
        logic [8:0]       tok_idx;
        logic [1:0]       skip_left;
        rct_pkg::t_result expected_tokens[$];
        int               err_count;

        function new();
            err_count = 0;
            clear_state();
        endfunction

        function void clear_state();
            phase      = rct_pkg::PH_FIRST;
            tok_open   = 1'b0;
            num_acc    = '0;
            elems_left = '0;
            bytes_left = '0;
            tok_idx    = '0;
            skip_left  = '0;
        endfunction

        function void push(rct_pkg::t_kind k, logic [7:0] b, rct_pkg::t_status st);
            rct_pkg::t_result r;
            r.kind        = k;
            r.token_byte  = b;
            r.token_index = tok_idx[7:0];
            r.status      = st;
            r.token_count = (k == rct_pkg::KIND_FINISH) ? tok_idx : 9'd0;
            r.run_last    = 1'b0;
            expected_tokens.insert(expected_tokens.size(), r);
        endfunction

        // decimal digits with saturation; true once cr lf closes the number
        function bit digit_step(logic [7:0] b, int limit, rct_pkg::t_phase num_ph,
                                rct_pkg::t_phase lf_ph);
            int v;
            if (phase == lf_ph) begin
                if (b == rct_pkg::CH_LF) return 1'b1;
                if (b == rct_pkg::CH_CR) return 1'b0;
                phase = num_ph;
            end
            if (b == rct_pkg::CH_CR) begin
                phase = lf_ph;
            end else if (b >= rct_pkg::CH_ZERO && b <= rct_pkg::CH_NINE) begin
                v = int'(num_acc) * 10 + int'(b) - int'(rct_pkg::CH_ZERO);
                num_acc = (v > limit) ? 17'(limit) : 17'(v);
            end
            return 1'b0;
        endfunction

        // whitespace split mode
        function void split_byte(logic [7:0] b);
            bit ws;
            ws = (b == rct_pkg::CH_SPACE) || (b >= rct_pkg::CH_TAB && b <= rct_pkg::CH_CR);
            if (ws) begin
                if (tok_open) begin
                    push(rct_pkg::KIND_END, 8'h00, rct_pkg::ST_OK);
                    tok_open = 1'b0;
                    tok_idx++;
                end
                return;
            end
            if (!tok_open) begin
                if (tok_idx >= rct_pkg::MAX_ELEMENTS) begin
                    phase = rct_pkg::PH_STOP;
                    return;
                end
                tok_open = 1'b1;
            end
            push(rct_pkg::KIND_BYTE, b, rct_pkg::ST_OK);
        endfunction

        // a bulk string is complete, two bytes to skip follow
        function void close_bulk();
            push(rct_pkg::KIND_END, 8'h00, rct_pkg::ST_OK);
            tok_idx++;
            if (elems_left != 0) elems_left--;
            skip_left = 2'd2;
            phase     = rct_pkg::PH_SKIP;
        endfunction

        function void note_request(logic [7:0] b, logic last);
            int               start;
            rct_pkg::t_status st;
            start = expected_tokens.size();
            case (phase)
                rct_pkg::PH_FIRST: begin
                    if (b == rct_pkg::CH_STAR) begin
                        num_acc = '0;
                        phase   = rct_pkg::PH_COUNT;
                    end else begin
                        phase = rct_pkg::PH_INLINE;
                        split_byte(b);
                    end
                end
                rct_pkg::PH_INLINE: split_byte(b);
                rct_pkg::PH_COUNT, rct_pkg::PH_COUNT_LF: begin
                    if (digit_step(b, rct_pkg::MAX_ELEMENTS, rct_pkg::PH_COUNT,
                                   rct_pkg::PH_COUNT_LF)) begin
                        elems_left = num_acc[8:0];
                        phase = (elems_left != 0) ? rct_pkg::PH_DOLLAR : rct_pkg::PH_DONE;
                    end
                end
                rct_pkg::PH_DOLLAR: begin
                    if (b == rct_pkg::CH_DOLLAR) begin
                        num_acc = '0;
                        phase   = rct_pkg::PH_LEN;
                    end else begin
                        phase = rct_pkg::PH_STOP;
                    end
                end
                rct_pkg::PH_LEN, rct_pkg::PH_LEN_LF: begin
                    if (digit_step(b, rct_pkg::MAX_BULK_LEN, rct_pkg::PH_LEN,
                                   rct_pkg::PH_LEN_LF)) begin
                        bytes_left = num_acc;
                        if (bytes_left == 0) close_bulk();
                        else phase = rct_pkg::PH_PAYLOAD;
                    end
                end
                rct_pkg::PH_PAYLOAD: begin
                    push(rct_pkg::KIND_BYTE, b, rct_pkg::ST_OK);
                    if (bytes_left != 0) bytes_left--;
                    if (bytes_left == 0) close_bulk();
                end
                rct_pkg::PH_SKIP: begin
                    if (skip_left != 0) skip_left--;
                    if (skip_left == 0) begin
                        phase = (elems_left != 0) ? rct_pkg::PH_DOLLAR : rct_pkg::PH_DONE;
                    end
                end
                rct_pkg::PH_DONE: ;
                default: phase = rct_pkg::PH_STOP;
            endcase

            // final byte closes an open token and reports the message status
            if (last) begin
                if (phase == rct_pkg::PH_INLINE && tok_open) begin
                    push(rct_pkg::KIND_END, 8'h00, rct_pkg::ST_OK);
                    tok_idx++;
                    tok_open = 1'b0;
                end
                case (phase)
                    rct_pkg::PH_INLINE, rct_pkg::PH_DONE: st = rct_pkg::ST_OK;
                    rct_pkg::PH_PAYLOAD:                  st = rct_pkg::ST_TRUNC;
                    rct_pkg::PH_SKIP:
                        st = (elems_left != 0) ? rct_pkg::ST_STOP : rct_pkg::ST_OK;
                    default:                              st = rct_pkg::ST_STOP;
                endcase
                push(rct_pkg::KIND_FINISH, 8'h00, st);
                clear_state();
            end

            if (expected_tokens.size() > start) begin
                expected_tokens[expected_tokens.size() - 1].run_last = 1'b1;
            end
        endfunction

        task report(string what);
            $display("mismatch at %0t: %s", $time, what);
            err_count++;
        endtask

        task check_result(input logic [1:0] kind, input logic [7:0] tbyte,
                          input logic [7:0] tidx, input logic [1:0] st,
                          input logic [8:0] cnt, input logic rl);
            rct_pkg::t_result e;
            if (expected_tokens.size() == 0) begin
                report($sformatf("unexpected result kind %0d index %0d", kind, tidx));
                return;
            end
            e = expected_tokens.pop_front();
            if (kind !== e.kind || tbyte !== e.token_byte || tidx !== e.token_index ||
                st !== e.status || cnt !== e.token_count || rl !== e.run_last) begin
                report($sformatf(
                    "got k%0d b%02h i%0d s%0d c%0d l%0b, want k%0d b%02h i%0d s%0d c%0d l%0b",
                    kind, tbyte, tidx, st, cnt, rl, e.kind, e.token_byte,
                    e.token_index, e.status, e.token_count, e.run_last));
            end
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n;

    rct_in_if  req_ch ();
    rct_out_if res_ch ();

    resp_command_tokenizer_core dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (req_ch),
        .o_out   (res_ch)
    );

    tokenizer_scoreboard sb = new();

    logic [7:0] msg[$];
    int         sent_bytes     = 0;
    int         accepted_count = 0;
    int         cycle_count    = 0;
    bit         no_idle        = 1'b0;
    bit         held_off       = 1'b0;

    always #5 clk = ~clk;

    // watchdog
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[resp_command_tokenizer_core] ERROR");
            $finish;
        end
    end

    // note accepted requests, then check accepted results
    always @(posedge clk) begin
        if (rst_n) begin
            if (req_ch.valid && req_ch.ready) begin
                sb.note_request(req_ch.in_byte, req_ch.last_byte);
                accepted_count++;
            end
            if (res_ch.valid && res_ch.ready) begin
                sb.check_result(res_ch.kind, res_ch.token_byte, res_ch.token_index,
                                res_ch.status, res_ch.token_count, res_ch.run_last);
            end
        end
    end

    // result side: random stalls, one long hold-off, none near the end
    initial begin
        res_ch.ready <= 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever begin
            if (no_idle) begin
                res_ch.ready <= 1'b1;
                @(posedge clk);
            end else if (!held_off && accepted_count >= HOLD_AFTER) begin
                held_off = 1'b1;
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end else if ($urandom_range(0, 2) == 0) begin
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end else begin
                res_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
        end
    end

    // offer one byte and wait for its handshake
    task automatic send_request(input logic [7:0] b, input logic last);
        req_ch.valid     <= 1'b1;
        req_ch.in_byte   <= b;
        req_ch.last_byte <= last;
        @(posedge clk);
        while (!req_ch.ready) @(posedge clk);
        sent_bytes++;
    endtask

    // send the built message, last flag on its final byte
    task automatic send_message();
        bit calm;
        calm = no_idle || ($urandom_range(0, 3) == 0);
        for (int i = 0; i < msg.size(); i++) begin
            if (!calm && $urandom_range(0, 4) == 0) begin
                req_ch.valid <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
            send_request(msg[i], i == msg.size() - 1);
        end
        msg.delete();
    endtask

    // append one byte to the message under construction
    task automatic add_byte(input logic [7:0] b);
        msg.insert(msg.size(), b);
    endtask

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++) add_byte(s[i]);
    endtask

    // a byte that is neither a digit nor cr nor lf
    function automatic logic [7:0] junk_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255));
        while ((b >= rct_pkg::CH_ZERO && b <= rct_pkg::CH_NINE) ||
               b == rct_pkg::CH_CR || b == rct_pkg::CH_LF);
        return b;
    endfunction

    task automatic put_space();
        int r;
        repeat ($urandom_range(1, 3)) begin
            r = $urandom_range(0, 5);
            add_byte((r == 0) ? rct_pkg::CH_SPACE : 8'(rct_pkg::CH_TAB + r - 1));
        end
    endtask

    // decimal number and its cr lf, optionally with junk that leaves the value alone
    task automatic put_number(input int n, input bit noisy);
        string s;
        s = $sformatf("%0d", n);
        if (noisy && n == 0 && $urandom_range(0, 1) == 1) s = "";
        if (noisy && $urandom_range(0, 1) == 1) add_byte(rct_pkg::CH_ZERO);
        for (int i = 0; i < s.len(); i++) begin
            if (noisy && $urandom_range(0, 3) == 0) add_byte(junk_byte());
            add_byte(s[i]);
        end
        if (noisy) begin
            case ($urandom_range(0, 2))
                0: begin
                    add_byte(rct_pkg::CH_CR);
                    add_byte(junk_byte());
                end
                1: add_byte(rct_pkg::CH_CR);
                default: ;
            endcase
        end
        add_byte(rct_pkg::CH_CR);
        add_byte(rct_pkg::CH_LF);
    endtask

    // array of bulk strings with random content, sometimes broken or cut short
    task automatic build_array();
        int n, elems, len, r;
        bit noisy;
        noisy = ($urandom_range(0, 4) == 0);
        add_byte(rct_pkg::CH_STAR);
        r = $urandom_range(0, 19);
        if (r == 0) n = 0;
        else if (r == 1) n = $urandom_range(rct_pkg::MAX_ELEMENTS + 1, 99999);
        else if (r == 2) n = rct_pkg::MAX_ELEMENTS;
        else n = $urandom_range(1, 4);
        put_number(n, noisy);
        elems = (n > 4) ? $urandom_range(1, 3) : n + (($urandom_range(0, 7) == 0) ? 1 : 0);
        for (int i = 0; i < elems; i++) begin
            // 0..35 never hits the dollar sign
            if ($urandom_range(0, 24) == 0) add_byte(8'($urandom_range(0, 35)));
            else add_byte(rct_pkg::CH_DOLLAR);
            r = $urandom_range(0, 29);
            if (r == 0) begin
                // saturated length, the message ends inside the payload
                put_number($urandom_range(rct_pkg::MAX_BULK_LEN, 9999999), noisy);
                repeat ($urandom_range(1, 4)) add_byte(8'($urandom_range(0, 255)));
                break;
            end
            len = (r < 4) ? $urandom_range(7, 24) : $urandom_range(0, 6);
            put_number(len, noisy);
            repeat (len) add_byte(8'($urandom_range(0, 255)));
            if ($urandom_range(0, 7) == 0) begin
                repeat (2) add_byte(8'($urandom_range(0, 255)));
            end else begin
                add_byte(rct_pkg::CH_CR);
                add_byte(rct_pkg::CH_LF);
            end
        end
        if ($urandom_range(0, 5) == 0) begin
            repeat ($urandom_range(1, 4)) add_byte(8'($urandom_range(0, 255)));
        end
        if ($urandom_range(0, 3) == 0) begin
            r = $urandom_range(1, msg.size());
            while (msg.size() > r) void'(msg.pop_back());
        end
    endtask

    // whitespace separated words of random non-blank bytes
    task automatic build_words();
        logic [7:0] b;
        int ntok;
        if ($urandom_range(0, 1) == 1) put_space();
        ntok = $urandom_range(0, 5);
        for (int i = 0; i < ntok; i++) begin
            if (i > 0) put_space();
            repeat ($urandom_range(1, 6)) begin
                do b = 8'($urandom_range(0, 255));
                while (b == rct_pkg::CH_SPACE ||
                       (b >= rct_pkg::CH_TAB && b <= rct_pkg::CH_CR));
                add_byte(b);
            end
        end
        if (msg.size() == 0 || $urandom_range(0, 1) == 1) put_space();
        if (msg[0] == rct_pkg::CH_STAR) msg[0] = rct_pkg::CH_SPACE;
    endtask

    initial begin
        int start;
        int pick;
        rst_n            <= 1'b0;
        req_ch.valid     <= 1'b0;
        req_ch.in_byte   <= 8'h00;
        req_ch.last_byte <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed: open token at the final byte
        put_text("a");
        send_message();
        // zero count
        put_text("*0\r\n");
        send_message();
        // zero length, unchecked skip bytes, then a missing dollar
        put_text("*2\r\n$0\r\n");
        add_byte(8'hFF);
        add_byte(8'h00);
        put_text("X");
        send_message();
        // message ends inside a payload
        put_text("*1\r\n$3\r\na");
        send_message();
        // final byte lands in the skip bytes of the last element
        put_text("*1\r\n$0\r\n");
        add_byte(rct_pkg::CH_CR);
        send_message();

        // random messages
        start = sent_bytes;
        while (sent_bytes - start < RANDOM_BYTES) begin
            no_idle = (sent_bytes - start >= CALM_FROM);
            pick = $urandom_range(0, 9);
            if (pick < 6) begin
                build_array();
            end else if (pick < 9) begin
                build_words();
            end else begin
                repeat ($urandom_range(1, 8)) add_byte(8'($urandom_range(0, 255)));
                if ($urandom_range(0, 1) == 1) msg[0] = rct_pkg::CH_STAR;
            end
            send_message();
        end
        no_idle = 1'b1;
        req_ch.valid <= 1'b0;

        // drain
        while (sb.expected_tokens.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.err_count == 0) begin
            $display("[resp_command_tokenizer_core] OK");
        end else begin
            $display("[resp_command_tokenizer_core] ERROR");
        end
        $finish;
    end

endmodule

// ===== files.f =====
design/rct_pkg.sv
design/rct_if.sv
design/rct_parser.sv
design/rct_outq.sv
design/resp_command_tokenizer_core.sv
design/rct_checker.sv
verif/resp_command_tokenizer_core_test.sv
